// ----- hdl/utfd_pkg.sv -----
`timescale 1ns / 1ps

package utfd_pkg;

	localparam int CODE_POINT_W = 32;
	localparam int COUNTER_W    = 32;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 1;

	// Depth of the character queue between the front and the back.
	localparam int QUEUE_DEPTH_DEFAULT = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_START_LINE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_START_COLUMN = 1'd1;

	localparam logic [COUNTER_W-1:0] START_DEFAULT = 32'd1;

	// Byte order mark bytes and the offsets that strip the UTF-8 marker bits.
	localparam logic [7:0] BOM_BYTE0 = 8'd239;
	localparam logic [7:0] BOM_BYTE1 = 8'd187;
	localparam logic [7:0] BOM_BYTE2 = 8'd191;
	localparam logic [CODE_POINT_W-1:0] OFFSET_2B = 32'h0000_3080;
	localparam logic [CODE_POINT_W-1:0] OFFSET_3B = 32'h000E_2080;
	localparam logic [CODE_POINT_W-1:0] OFFSET_4B = 32'h03C8_2080;
	localparam logic [CODE_POINT_W-1:0] NEWLINE_CP = 32'd10;

	typedef enum logic [1:0] {
		STATUS_VALID   = 2'd0,
		STATUS_TRUNC   = 2'd1,
		STATUS_INVALID = 2'd2
	} status_t;

	// One decoded character on its way from the front to the back.
	typedef struct packed {
		logic [CODE_POINT_W-1:0] code_point;
		status_t                 status;
		logic                    newline;
		logic                    load;
		logic [COUNTER_W-1:0]    load_line;
		logic [COUNTER_W-1:0]    load_column;
	} char_item_t;

endpackage

// ----- hdl/utf8_decoder_with_position_top.sv -----
`timescale 1ns / 1ps

// UTF-8 decoder with line and column tracking.
// Input channel: one raw byte per item on in_byte, with end_of_stream set on
// the last byte of a stream. An item moves when byte_valid is high and
// byte_stall is low. Output channel: one decoded character per item with its
// code point, status, and the line and column after that character, moved
// when char_valid is high and char_stall is low.
// Continuation bytes produce no item; a leading byte order mark is dropped.
// One byte is accepted every cycle while the queue is not full. The byte
// completing a character is decoded in the cycle it is accepted, and the
// character is written into the character queue at that edge; it moves on
// into the output register when it is the oldest and the output is not stalled.
// The configuration port sets start_line and start_column; they are loaded
// into the counters at the first byte of every stream.
// Reset clears the queue and the output, returns both start values to 1 and
// marks the next byte as the start of a stream. While the receiver stalls the
// output holds its item, the queue keeps filling, and byte_stall rises only
// once the queue is full.
module utf8_decoder_with_position_top
	import utfd_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT  // two or more
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [7:0]              in_byte,
	input  logic                    end_of_stream,
	output logic                    char_valid,
	input  logic                    char_stall,
	output logic [CODE_POINT_W-1:0] code_point,
	output logic [1:0]              status,
	output logic [COUNTER_W-1:0]    line_number,
	output logic [COUNTER_W-1:0]    column_number
);

	// Front to queue: one decoded character, pushed in the cycle its last byte
	// is accepted. Queue to back: the oldest character and a pop strobe.
	logic       push;
	char_item_t push_item;
	logic       queue_full;
	logic       queue_not_empty;
	logic       pop;
	char_item_t pop_item;

	// The front holds partial sequences, builds code points and flags the
	// first character of each stream so that the back reloads its counters.
	utfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.end_of_stream(end_of_stream),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	utfd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.pop      (pop),
		.pop_item (pop_item)
	);

	// The back owns the line and column counters and the output register.
	utfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.not_empty    (queue_not_empty),
		.pop_item     (pop_item),
		.pop          (pop),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.code_point   (code_point),
		.status       (status),
		.line_number  (line_number),
		.column_number(column_number)
	);

endmodule

// ----- hdl/utfd_front.sv -----
`timescale 1ns / 1ps

module utfd_front
	import utfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             in_byte,
	input  logic                   end_of_stream,
	input  logic                   queue_full,
	output logic                   push,
	output char_item_t             push_item
);

	logic [COUNTER_W-1:0] start_line_q;
	logic [COUNTER_W-1:0] start_column_q;
	logic [COUNTER_W-1:0] snap_line_q;
	logic [COUNTER_W-1:0] snap_column_q;
	logic [23:0]          held_bytes_q;
	logic [1:0]           held_count_q;
	logic                 first_pending_q;
	logic                 load_pending_q;

	logic                    fire;
	logic                    load_now;
	logic [7:0]              b0;
	logic [7:0]              b1;
	logic [7:0]              b2;
	logic [2:0]              need;
	logic [2:0]              have;
	logic                    complete;
	logic                    bom;
	logic [CODE_POINT_W-1:0] cp;
	status_t                 st;

	assign byte_stall = queue_full;
	assign fire       = byte_valid && !byte_stall;
	assign load_now   = first_pending_q && (held_count_q == 2'd0);

	assign b0 = (held_count_q == 2'd0) ? in_byte : held_bytes_q[7:0];
	assign b1 = held_bytes_q[15:8];
	assign b2 = held_bytes_q[23:16];

	always_comb begin
		if (!b0[7]) begin
			need = 3'd1;
		end else if (!b0[5]) begin
			need = 3'd2;
		end else if (!b0[4]) begin
			need = 3'd3;
		end else begin
			need = 3'd4;
		end
	end

	assign have     = {1'b0, held_count_q} + 3'd1;
	assign complete = (have >= need);
	assign bom = first_pending_q && (need == 3'd3) && !end_of_stream &&
		(b0 == BOM_BYTE0) && (b1 == BOM_BYTE1) && (in_byte == BOM_BYTE2);

	always_comb begin
		cp = '0;
		st = STATUS_VALID;
		if (!complete) begin
			st = STATUS_TRUNC;
		end else begin
			unique case (need)
				3'd1: cp = {24'd0, in_byte};
				3'd2: cp = ({24'd0, b0} << 6) + {24'd0, in_byte} - OFFSET_2B;
				3'd3: cp = ({24'd0, b0} << 12) + ({24'd0, b1} << 6) + {24'd0, in_byte}
					- OFFSET_3B;
				default: begin
					if (!b0[3]) begin
						cp = ({24'd0, b0} << 18) + ({24'd0, b1} << 12)
							+ ({24'd0, b2} << 6) + {24'd0, in_byte} - OFFSET_4B;
					end else begin
						st = STATUS_INVALID;
					end
				end
			endcase
		end
	end

	assign push = fire && (complete ? !bom : end_of_stream);

	// The first character pushed after a stream start carries the start
	// values, even when a dropped byte order mark came in between.
	always_comb begin
		push_item.code_point  = cp;
		push_item.status      = st;
		push_item.newline     = (st == STATUS_VALID) && (cp == NEWLINE_CP);
		push_item.load        = load_now || load_pending_q;
		push_item.load_line   = load_now ? start_line_q : snap_line_q;
		push_item.load_column = load_now ? start_column_q : snap_column_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_line_q   <= START_DEFAULT;
			start_column_q <= START_DEFAULT;
		end else if (cfg_write_en) begin
			if (cfg_index == REG_START_LINE) begin
				start_line_q <= cfg_data;
			end
			if (cfg_index == REG_START_COLUMN) begin
				start_column_q <= cfg_data;
			end
		end
	end

	// The counters take the start values seen at the first byte of a stream.
	always_ff @(posedge clk) begin
		if (fire && load_now) begin
			snap_line_q   <= start_line_q;
			snap_column_q <= start_column_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q    <= '0;
			held_count_q    <= '0;
			first_pending_q <= 1'b1;
			load_pending_q  <= 1'b0;
		end else if (fire) begin
			if (!complete && !end_of_stream) begin
				case (held_count_q)
					2'd0: held_bytes_q[7:0]   <= in_byte;
					2'd1: held_bytes_q[15:8]  <= in_byte;
					2'd2: held_bytes_q[23:16] <= in_byte;
					default: held_bytes_q     <= held_bytes_q;
				endcase
				held_count_q <= held_count_q + 2'd1;
			end else begin
				held_bytes_q <= '0;
				held_count_q <= '0;
			end
			if (end_of_stream) begin
				first_pending_q <= 1'b1;
			end else if (complete) begin
				first_pending_q <= 1'b0;
			end
			if (push) begin
				load_pending_q <= 1'b0;
			end else if (load_now) begin
				load_pending_q <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/utfd_queue.sv -----
`timescale 1ns / 1ps

module utfd_queue
	import utfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  char_item_t push_item,
	output logic       full,
	output logic       not_empty,
	input  logic       pop,
	output char_item_t pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	char_item_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_item  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/utfd_back.sv -----
`timescale 1ns / 1ps

module utfd_back
	import utfd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    not_empty,
	input  char_item_t              pop_item,
	output logic                    pop,
	output logic                    char_valid,
	input  logic                    char_stall,
	output logic [CODE_POINT_W-1:0] code_point,
	output logic [1:0]              status,
	output logic [COUNTER_W-1:0]    line_number,
	output logic [COUNTER_W-1:0]    column_number
);

	logic [COUNTER_W-1:0]    line_q;
	logic [COUNTER_W-1:0]    column_q;
	logic                    valid_q;
	logic [CODE_POINT_W-1:0] cp_q;
	status_t                 status_q;
	logic [COUNTER_W-1:0]    base_line;
	logic [COUNTER_W-1:0]    base_column;
	logic [COUNTER_W-1:0]    next_line;
	logic [COUNTER_W-1:0]    next_column;

	assign pop = not_empty && (!valid_q || !char_stall);

	assign base_line   = pop_item.load ? pop_item.load_line : line_q;
	assign base_column = pop_item.load ? pop_item.load_column : column_q;

	always_comb begin
		if (pop_item.newline) begin
			next_line   = base_line + COUNTER_W'(1);
			next_column = COUNTER_W'(1);
		end else begin
			next_line   = base_line;
			next_column = base_column + COUNTER_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= START_DEFAULT;
			column_q <= START_DEFAULT;
			valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				line_q   <= next_line;
				column_q <= next_column;
				valid_q  <= 1'b1;
			end else if (!char_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cp_q     <= pop_item.code_point;
			status_q <= pop_item.status;
		end
	end

	assign char_valid    = valid_q;
	assign code_point    = cp_q;
	assign status        = status_q;
	assign line_number   = line_q;
	assign column_number = column_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the UTF-8 decoder with line and column tracking.
// Bytes are pushed one item at a time through the byte channel while a
// software decoder in this module follows every accepted byte and queues the
// character it expects. Every character that leaves the block is compared
// against the oldest queued character, field by field.
module tb;
	import utfd_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int PHASE_BYTES   = 425;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_LIMIT  = 10;

	// One decoded character as it should appear on the output channel.
	typedef struct packed {
		logic [CODE_POINT_W-1:0] code_point;
		status_t                 status;
		logic [COUNTER_W-1:0]    line_number;
		logic [COUNTER_W-1:0]    column_number;
	} decoded_char_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write_en = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index = REG_START_LINE;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    byte_valid = 1'b0;
	logic                    byte_stall;
	logic [7:0]              in_byte = 8'd0;
	logic                    end_of_stream = 1'b0;
	logic                    char_valid;
	logic                    char_stall = 1'b0;
	logic [CODE_POINT_W-1:0] code_point;
	logic [1:0]              status;
	logic [COUNTER_W-1:0]    line_number;
	logic [COUNTER_W-1:0]    column_number;

	// Shadow copy of the decoder state and of the two start registers.
	logic [COUNTER_W-1:0] shadow_start_line = START_DEFAULT;
	logic [COUNTER_W-1:0] shadow_start_column = START_DEFAULT;
	logic [23:0]          shadow_held_bytes = '0;
	logic [1:0]           shadow_held_count = '0;
	logic                 shadow_new_stream = 1'b1;
	logic [COUNTER_W-1:0] shadow_line = START_DEFAULT;
	logic [COUNTER_W-1:0] shadow_column = START_DEFAULT;

	decoded_char_t expected_chars [$];
	decoded_char_t head_char;

	bit idling_on = 1'b1;
	int bytes_sent = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int rx_hold_left = 0;

	utf8_decoder_with_position_top dut (.*);

	always #HALF_PERIOD clk = ~clk;

	// Watchdog. A run that hangs on a handshake ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// The receiver stalls in random bursts of random length. Each burst
	// starts with one stalled cycle and then may hold for a random while.
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			char_stall <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			char_stall <= 1'b1;
			rx_hold_left <= $urandom_range(0, 7);
		end else begin
			char_stall <= 1'b0;
		end
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%s", msg);
		end
	endtask

	// Output check. Values are read right after the edge, so they are the
	// ones that were present when the handshake was decided.
	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall) begin
			if (expected_chars.size() == 0) begin
				note_failure($sformatf(
					"unexpected char: cp=%h status=%0d line=%0d col=%0d",
					code_point, status, line_number, column_number));
			end else begin
				head_char = expected_chars.pop_front();
				if (code_point !== head_char.code_point || status !== head_char.status ||
						line_number !== head_char.line_number ||
						column_number !== head_char.column_number) begin
					note_failure($sformatf({"char mismatch: exp cp=%h st=%0d ln=%0d col=%0d,",
						" got cp=%h st=%0d ln=%0d col=%0d"},
						head_char.code_point, head_char.status, head_char.line_number,
						head_char.column_number, code_point, status, line_number,
						column_number));
				end
			end
		end
	end

	task automatic queue_char(input logic [CODE_POINT_W-1:0] cp, input status_t st);
		decoded_char_t entry;
		entry.code_point = cp;
		entry.status = st;
		entry.line_number = shadow_line;
		entry.column_number = shadow_column;
		expected_chars.insert(expected_chars.size(), entry);
	endtask

	// Follows one accepted byte through the decoder and queues the character
	// it finishes, if any. The sequence length comes from the lead byte only.
	task automatic predict_char_from_byte(input logic [7:0] value, input logic last);
		logic [7:0]              lead;
		logic [7:0]              cont1;
		logic [7:0]              cont2;
		logic [CODE_POINT_W-1:0] cp;
		status_t                 st;
		int                      need;

		// The first byte of a stream reloads both counters.
		if (shadow_new_stream && shadow_held_count == 2'd0) begin
			shadow_line = shadow_start_line;
			shadow_column = shadow_start_column;
		end
		lead = (shadow_held_count == 2'd0) ? value : shadow_held_bytes[7:0];
		cont1 = shadow_held_bytes[15:8];
		cont2 = shadow_held_bytes[23:16];
		if (lead < 8'h80) need = 1;
		else if (!lead[5]) need = 2;
		else if (!lead[4]) need = 3;
		else need = 4;
		cp = '0;
		st = STATUS_VALID;

		if (int'(shadow_held_count) + 1 < need) begin
			if (!last) begin
				shadow_held_bytes[8 * shadow_held_count +: 8] = value;
				shadow_held_count = shadow_held_count + 2'd1;
				return;
			end
			// The stream ends in the middle of a sequence.
			shadow_column = shadow_column + 1;
			queue_char('0, STATUS_TRUNC);
		end else begin
			case (need)
				1: cp = 32'(value);
				2: cp = (32'(lead) << 6) + 32'(value) - OFFSET_2B;
				3: cp = (32'(lead) << 12) + (32'(cont1) << 6) + 32'(value) - OFFSET_3B;
				default: begin
					if (!lead[3]) begin
						cp = (32'(lead) << 18) + (32'(cont1) << 12) + (32'(cont2) << 6) +
							32'(value) - OFFSET_4B;
					end else begin
						st = STATUS_INVALID;
					end
				end
			endcase
			shadow_held_bytes = '0;
			shadow_held_count = '0;
			// A byte order mark opening a stream vanishes, unless the stream
			// ends right on it.
			if (shadow_new_stream && need == 3 && !last && lead == BOM_BYTE0 &&
					cont1 == BOM_BYTE1 && value == BOM_BYTE2) begin
				shadow_new_stream = 1'b0;
				return;
			end
			shadow_new_stream = 1'b0;
			if (st == STATUS_VALID && cp == NEWLINE_CP) begin
				shadow_line = shadow_line + 1;
				shadow_column = 1;
			end else begin
				shadow_column = shadow_column + 1;
			end
			queue_char((st == STATUS_VALID) ? cp : '0, st);
		end

		if (last) begin
			shadow_held_bytes = '0;
			shadow_held_count = '0;
			shadow_new_stream = 1'b1;
		end
	endtask

	// Sends one byte item, sometimes after a random gap, and waits for the
	// edge that takes it. Valid stays high from one item to the next unless a gap is drawn.
	task automatic send_byte(input logic [7:0] value, input logic last);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= value;
		end_of_stream <= last;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		bytes_sent++;
		predict_char_from_byte(value, last);
	endtask

	// Drops valid and waits until every queued character has come out, then
	// a settle time for bytes that are still held inside the block.
	task automatic wait_until_idle();
		byte_valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the start line register and then the start column register, one after the other.
	task automatic write_start_values(input logic [31:0] line_start,
			input logic [31:0] column_start);
		cfg_write_en <= 1'b1;
		cfg_index <= REG_START_LINE;
		cfg_data <= line_start;
		@(posedge clk);
		cfg_index <= REG_START_COLUMN;
		cfg_data <= column_start;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		shadow_start_line = line_start;
		shadow_start_column = column_start;
	endtask

	task automatic test_ascii_and_newline();
		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	task automatic test_multibyte_forms();
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// A mark in front of text is dropped; a stream made of the mark alone
	// gives it back as an ordinary character.
	task automatic test_byte_order_mark();
		send_byte(BOM_BYTE0, 1'b0);
		send_byte(BOM_BYTE1, 1'b0);
		send_byte(BOM_BYTE2, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(BOM_BYTE0, 1'b0);
		send_byte(BOM_BYTE1, 1'b0);
		send_byte(BOM_BYTE2, 1'b1);
	endtask

	task automatic test_truncated_end();
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b1);
	endtask

	// A lead of 0xF8 or above still eats four bytes before it reports.
	task automatic test_invalid_leads();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	// Counters at the top of their range wrap to zero.
	task automatic test_start_value_extremes();
		wait_until_idle();
		write_start_values(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_byte(8'h41, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'h41, 1'b1);
	endtask

	// Builds one character with random content and sends it. Most of them are
	// well formed; some use a bad lead, some are cut short by the end of the
	// stream, some are byte order marks, and some are single noise bytes that break the sequence after.
	task automatic send_random_char(input bit end_here);
		logic [7:0] seq [4];
		int         pick;
		int         len;
		int         cut;
		int         k;

		for (k = 1; k < 4; k++) begin
			seq[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h80, 8'hBF));
		end
		pick = $urandom_range(0, 99);
		if (shadow_new_stream && shadow_held_count == 2'd0 && $urandom_range(0, 3) == 0) begin
			pick = 100;
		end
		if (pick < 30) begin
			len = 1;
			seq[0] = 8'($urandom_range(8'h00, 8'h7F));
		end else if (pick < 40) begin
			len = 1;
			seq[0] = 8'h0A;
		end else if (pick < 55) begin
			len = 2;
			seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
		end else if (pick < 70) begin
			len = 3;
			seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
		end else if (pick < 80) begin
			len = 4;
			seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
		end else if (pick < 86) begin
			len = 4;
			seq[0] = 8'($urandom_range(8'hF8, 8'hFF));
		end else if (pick < 90) begin
			len = 1;
			seq[0] = 8'($urandom);
		end else begin
			len = 3;
			seq[0] = BOM_BYTE0;
			seq[1] = BOM_BYTE1;
			seq[2] = BOM_BYTE2;
		end

		cut = len - 1;
		if (len > 1 && $urandom_range(0, 19) == 0) begin
			cut = $urandom_range(0, len - 2);
		end
		for (k = 0; k <= cut; k++) begin
			send_byte(seq[k], (k == cut) && (end_here || cut < len - 1));
		end
	endtask

	// Random streams in four phases, each with its own start values. The
	// last phase runs with neither side idling.
	task automatic test_random_streams();
		logic [31:0] line_starts [4];
		logic [31:0] column_starts [4];
		int          phase_first;

		line_starts = '{32'($urandom), 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 100))};
		column_starts = '{32'($urandom), 32'd0, 32'hFFFF_FFFF, 32'($urandom_range(1, 100))};
		for (int p = 0; p < 4; p++) begin
			wait_until_idle();
			write_start_values(line_starts[p], column_starts[p]);
			idling_on = (p != 3);
			phase_first = bytes_sent;
			while (bytes_sent - phase_first < PHASE_BYTES) begin
				send_random_char($urandom_range(0, 11) == 0);
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ascii_and_newline();
		test_multibyte_forms();
		test_byte_order_mark();
		test_truncated_end();
		test_invalid_leads();
		test_start_value_extremes();
		test_random_streams();

		// Every character has arrived once the queue is empty; the settle
		// cycles give a stray extra character time to show up.
		wait_until_idle();
		if (fail_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
